>>> sv/lbcc_pkg.sv
package lbcc_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;

    localparam int COL_W      = 10;
    localparam int PIX_W      = 8;
    localparam int COUNT_W    = 11;
    localparam int TAG_W      = 8;
    localparam int ENTRY_W    = TAG_W + COUNT_W;
    localparam int WSUM_W     = 48;
    localparam int TOTAL_W    = 32;
    localparam int BASE_W     = 11;
    localparam int FW_W       = 11;
    localparam int MW_W       = 16;
    localparam int PROD_W     = COL_W + COUNT_W;
    localparam int DIV_CNT_W  = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT  = 1'd1;

    localparam logic [COUNT_W-1:0]   COUNT_MAX  = 11'd2047;
    localparam logic [BASE_W-1:0]    BASE_MAX   = 11'd1023;
    localparam logic [BASE_W-1:0]    BASE_NONE  = 11'h7FF;
    localparam logic [FW_W-1:0]      FW_RESET   = 11'd640;
    localparam logic [MW_W-1:0]      MW_RESET   = 16'd10;
    localparam logic [COL_W-1:0]     LO_RESET   = COL_W'(640 / 3);
    localparam logic [FW_W-1:0]      DIV3_MUL   = 11'd683;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(WSUM_W - 1);
    localparam logic [TAG_W-1:0]     TAG_FIRST  = 8'd1;
    localparam logic [TAG_W-1:0]     TAG_LAST   = 8'hFF;

endpackage

>>> sv/lbcc_if.sv
interface lbcc_pix_if;
    logic                         valid;
    logic                         ready;
    logic [lbcc_pkg::COL_W-1:0]   col;
    logic [lbcc_pkg::PIX_W-1:0]   pixel;
    logic                         last_of_frame;

    modport source (output valid, col, pixel, last_of_frame, input ready);
    modport sink   (input valid, col, pixel, last_of_frame, output ready);
endinterface

interface lbcc_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [lbcc_pkg::BASE_W-1:0]  base_col;
    logic                                updated;
    logic [lbcc_pkg::TOTAL_W-1:0]        weight_sum;

    modport source (output valid, base_col, updated, weight_sum, input ready);
    modport sink   (input valid, base_col, updated, weight_sum, output ready);
endinterface

>>> sv/lane_base_column_centroid.sv
// lane base column finder for a binary lane mask
// pix channel: one mask pixel per item with its column and an end-of-frame
// mark; res channel: one item per frame with the base column, an updated
// flag and the frame's weight total. cfg_we/cfg_index/cfg_data write
// frame_width (index 0) and min_weight (index 1); the user must write them
// only while the block is idle; the block itself does not enforce this.
// within a frame one pixel is taken every cycle; per-column counts live in
// a 1024-entry memory with a registered read and a forwarded read-modify-
// write. after the last pixel the block stops taking pixels while it closes
// the frame, decides, runs the one-bit-a-cycle divider and loads the result
// register; a frame without a new base skips the divider.
// after reset, and after every 255th frame, a clearing pass writes all 1024
// memory entries, one a cycle; pixels are not taken then.
// the result register holds its item while res.ready is low; the next frame
// may stream in meanwhile but its result waits until the register is free.
// reset sets the held base to -1, frame_width to 640, min_weight to 10.
module lane_base_column_centroid
(
    input  logic                               clk,
    input  logic                               rst_n,
    lbcc_pix_if.sink                           pix,
    lbcc_res_if.source                         res,
    input  logic                               cfg_we,
    input  logic [lbcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [lbcc_pkg::FW_W-1:0]          frame_width_reg, frame_width_next;
    logic [lbcc_pkg::MW_W-1:0]          min_weight_reg, min_weight_next;
    logic [lbcc_pkg::COL_W-1:0]         win_lo_reg, win_lo_next;

    logic                               s1_valid_reg, s1_valid_next;
    logic                               s1_hit_reg, s1_hit_next;
    logic                               s1_last_reg, s1_last_next;
    logic [lbcc_pkg::COL_W-1:0]         s1_col_reg, s1_col_next;

    logic                               fwd_valid_reg, fwd_valid_next;
    logic [lbcc_pkg::COL_W-1:0]         fwd_col_reg, fwd_col_next;
    logic [lbcc_pkg::COUNT_W-1:0]       fwd_cnt_reg, fwd_cnt_next;

    logic [lbcc_pkg::TAG_W-1:0]         epoch_reg, epoch_next;
    logic [lbcc_pkg::COL_W-1:0]         clr_addr_reg, clr_addr_next;

    logic [lbcc_pkg::WSUM_W-1:0]        wsum_reg, wsum_next;
    logic [lbcc_pkg::TOTAL_W-1:0]       total_reg, total_next;
    logic [lbcc_pkg::BASE_W-1:0]        held_reg, held_next;
    logic                               upd_reg, upd_next;

    logic [lbcc_pkg::WSUM_W-1:0]        dvd_reg, dvd_next;
    logic [lbcc_pkg::TOTAL_W:0]         rem_reg, rem_next;
    logic [lbcc_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;

    logic                               out_valid_reg, out_valid_next;
    logic [lbcc_pkg::BASE_W-1:0]        out_base_reg, out_base_next;
    logic                               out_upd_reg, out_upd_next;
    logic [lbcc_pkg::TOTAL_W-1:0]       out_sum_reg, out_sum_next;

    logic [lbcc_pkg::ENTRY_W-1:0]       cnt_mem [lbcc_pkg::MAX_COLS];
    logic [lbcc_pkg::ENTRY_W-1:0]       mem_rdata_reg;
    logic                               mem_we;
    logic [lbcc_pkg::COL_W-1:0]         mem_waddr;
    logic [lbcc_pkg::ENTRY_W-1:0]       mem_wdata;

    logic                               accept;
    logic                               hit;
    logic [lbcc_pkg::COUNT_W-1:0]       cnt_old;
    logic [lbcc_pkg::COUNT_W-1:0]       cnt_new;
    logic [lbcc_pkg::PROD_W-1:0]        prod;
    logic [lbcc_pkg::WSUM_W:0]          wsum_add;
    logic [lbcc_pkg::TOTAL_W:0]         total_add;
    logic [2*lbcc_pkg::FW_W-1:0]        lo_prod;
    logic [lbcc_pkg::TOTAL_W:0]         rem_sh;
    logic [lbcc_pkg::TOTAL_W:0]         rem_sub;
    logic [lbcc_pkg::BASE_W-1:0]        q_sat;
    logic                               take_new;

    assign pix.ready = (state_reg == ST_RUN) && !(s1_valid_reg && s1_last_reg);
    assign accept    = pix.valid && pix.ready;

    assign hit = (pix.pixel != '0) && (pix.col >= win_lo_reg)
                 && ({1'b0, pix.col} < frame_width_reg);

    assign res.valid      = out_valid_reg;
    assign res.base_col   = out_base_reg;
    assign res.updated    = out_upd_reg;
    assign res.weight_sum = out_sum_reg;

    // column count with same-column forwarding from the previous write
    always_comb
    begin
        if (fwd_valid_reg && (fwd_col_reg == s1_col_reg))
        begin
            cnt_old = fwd_cnt_reg;
        end
        else if (mem_rdata_reg[lbcc_pkg::ENTRY_W-1:lbcc_pkg::COUNT_W] == epoch_reg)
        begin
            cnt_old = mem_rdata_reg[lbcc_pkg::COUNT_W-1:0];
        end
        else
        begin
            cnt_old = '0;
        end
        cnt_new   = (cnt_old == lbcc_pkg::COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
        prod      = lbcc_pkg::PROD_W'(s1_col_reg) * lbcc_pkg::PROD_W'(cnt_new);
        wsum_add  = {1'b0, wsum_reg} + (lbcc_pkg::WSUM_W + 1)'(prod);
        total_add = {1'b0, total_reg} + (lbcc_pkg::TOTAL_W + 1)'(cnt_new);
    end

    assign lo_prod = {{lbcc_pkg::FW_W{1'b0}}, cfg_data[lbcc_pkg::FW_W-1:0]}
                     * {{lbcc_pkg::FW_W{1'b0}}, lbcc_pkg::DIV3_MUL};

    assign rem_sh  = {rem_reg[lbcc_pkg::TOTAL_W-1:0], dvd_reg[lbcc_pkg::WSUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, total_reg};

    assign q_sat = (dvd_reg[lbcc_pkg::WSUM_W-1:lbcc_pkg::COL_W] != '0)
                   ? lbcc_pkg::BASE_MAX : {1'b0, dvd_reg[lbcc_pkg::COL_W-1:0]};

    assign take_new = ((total_reg > lbcc_pkg::TOTAL_W'(min_weight_reg))
                       || (held_reg == lbcc_pkg::BASE_NONE)) && (total_reg != '0);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_valid_reg && s1_hit_reg;
            mem_waddr = s1_col_reg;
            mem_wdata = {epoch_reg, cnt_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cnt_mem[pix.col];
    end

    always_comb
    begin
        state_next       = state_reg;
        frame_width_next = frame_width_reg;
        min_weight_next  = min_weight_reg;
        win_lo_next      = win_lo_reg;
        s1_valid_next    = accept;
        s1_hit_next      = hit;
        s1_last_next     = pix.last_of_frame;
        s1_col_next      = pix.col;
        fwd_valid_next   = s1_valid_reg && s1_hit_reg && !s1_last_reg;
        fwd_col_next     = s1_col_reg;
        fwd_cnt_next     = cnt_new;
        epoch_next       = epoch_reg;
        clr_addr_next    = clr_addr_reg;
        wsum_next        = wsum_reg;
        total_next       = total_reg;
        held_next        = held_reg;
        upd_next         = upd_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_base_next    = out_base_reg;
        out_upd_next     = out_upd_reg;
        out_sum_next     = out_sum_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                lbcc_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data[lbcc_pkg::FW_W-1:0];
                    win_lo_next      = lo_prod[lbcc_pkg::FW_W +: lbcc_pkg::COL_W];
                end
                lbcc_pkg::CFG_MIN_WEIGHT:
                begin
                    min_weight_next = cfg_data[lbcc_pkg::MW_W-1:0];
                end
                default:
                begin
                    min_weight_next = min_weight_reg;
                end
            endcase
        end

        if (s1_valid_reg && s1_hit_reg)
        begin
            wsum_next  = wsum_add[lbcc_pkg::WSUM_W] ? '1 : wsum_add[lbcc_pkg::WSUM_W-1:0];
            total_next = total_add[lbcc_pkg::TOTAL_W]
                         ? '1 : total_add[lbcc_pkg::TOTAL_W-1:0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    epoch_next = lbcc_pkg::TAG_FIRST;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                upd_next = take_new;
                if (take_new)
                begin
                    dvd_next     = wsum_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (rem_sub[lbcc_pkg::TOTAL_W])
                begin
                    rem_next = rem_sh;
                    dvd_next = {dvd_reg[lbcc_pkg::WSUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = rem_sub;
                    dvd_next = {dvd_reg[lbcc_pkg::WSUM_W-2:0], 1'b1};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == lbcc_pkg::DIV_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_base_next  = upd_reg ? q_sat : held_reg;
                    out_upd_next   = upd_reg;
                    out_sum_next   = total_reg;
                    held_next      = upd_reg ? q_sat : held_reg;
                    wsum_next      = '0;
                    total_next     = '0;
                    if (epoch_reg == lbcc_pkg::TAG_LAST)
                    begin
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            frame_width_reg <= lbcc_pkg::FW_RESET;
            min_weight_reg  <= lbcc_pkg::MW_RESET;
            win_lo_reg      <= lbcc_pkg::LO_RESET;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            epoch_reg       <= '0;
            clr_addr_reg    <= '0;
            wsum_reg        <= '0;
            total_reg       <= '0;
            held_reg        <= lbcc_pkg::BASE_NONE;
            upd_reg         <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_width_reg <= frame_width_next;
            min_weight_reg  <= min_weight_next;
            win_lo_reg      <= win_lo_next;
            s1_valid_reg    <= s1_valid_next;
            fwd_valid_reg   <= fwd_valid_next;
            epoch_reg       <= epoch_next;
            clr_addr_reg    <= clr_addr_next;
            wsum_reg        <= wsum_next;
            total_reg       <= total_next;
            held_reg        <= held_next;
            upd_reg         <= upd_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hit_reg   <= s1_hit_next;
        s1_last_reg  <= s1_last_next;
        s1_col_reg   <= s1_col_next;
        fwd_col_reg  <= fwd_col_next;
        fwd_cnt_reg  <= fwd_cnt_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        out_base_reg <= out_base_next;
        out_upd_reg  <= out_upd_next;
        out_sum_reg  <= out_sum_next;
    end

    a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s1_valid_reg)
        else $error("item in flight during clearing pass");

    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready && pix.last_of_frame |=> !pix.ready)
        else $error("pixel taken while frame closes");

    a_new_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.updated |-> !res.base_col[lbcc_pkg::BASE_W-1])
        else $error("new base column out of range");

    a_new_base_has_weight: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.updated |-> res.weight_sum != '0)
        else $error("new base from empty frame");

endmodule
